// ===== hdl/sha1_hash_engine_macros.svh =====
// Assertion macros shared by the SHA-1 engine RTL.
// Expects i_clk and i_rst_n (synchronous, active low) in the including module.
`ifndef SHA1_HASH_ENGINE_MACROS_SVH
`define SHA1_HASH_ENGINE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SHA1_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SHA1_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/sha1_pkg.sv =====
// Types and constants of the SHA-1 engine.
// Used by sha1_round and sha1_hash_engine; no dependencies.
`default_nettype none

package sha1_pkg;

    typedef logic [31:0] t_word;

    // Working variables of the compression.
    typedef struct packed {
        t_word a;
        t_word b;
        t_word c;
        t_word d;
        t_word e;
    } t_work;

    localparam int unsigned DIGEST_LEN = 5;

    localparam t_word H_INIT [DIGEST_LEN] = '{
        32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE, 32'h1032_5476, 32'hC3D2_E1F0
    };

    localparam t_word K_RND [4] = '{
        32'h5A82_7999, 32'h6ED9_EBA1, 32'h8F1B_BCDC, 32'hCA62_C1D6
    };

    // Round counter bounds.
    localparam logic [6:0] ROUNDS   = 7'd80;
    localparam logic [6:0] RND_PH1  = 7'd20;
    localparam logic [6:0] RND_PH2  = 7'd40;
    localparam logic [6:0] RND_PH3  = 7'd60;

    // Byte positions within a 64-byte block.
    localparam logic [5:0] POS_LAST = 6'd63;
    localparam logic [5:0] POS_LEN  = 6'd56;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [2:0] DIGEST_WORDS = 3'd5;

    // Input operation codes.
    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINISH = 1'b1;

endpackage

`default_nettype wire

// ===== hdl/sha1_round.sv =====
// One SHA-1 round plus the next message schedule word, combinational.
// Depends on sha1_pkg.
`default_nettype none

module sha1_round (
    input  sha1_pkg::t_work i_work,
    input  logic [6:0]      i_rnd,
    input  sha1_pkg::t_word i_w0,
    input  sha1_pkg::t_word i_w2,
    input  sha1_pkg::t_word i_w8,
    input  sha1_pkg::t_word i_w13,
    output sha1_pkg::t_work o_work,
    output sha1_pkg::t_word o_sched
);
    import sha1_pkg::*;

    t_word f;
    t_word k;
    t_word mix;
    t_word t;

    always_comb begin
        if (i_rnd < RND_PH1) begin
            f = (i_work.b & i_work.c) | (~i_work.b & i_work.d);
            k = K_RND[0];
        end else if (i_rnd < RND_PH2) begin
            f = i_work.b ^ i_work.c ^ i_work.d;
            k = K_RND[1];
        end else if (i_rnd < RND_PH3) begin
            f = (i_work.b & i_work.c) | (i_work.b & i_work.d) | (i_work.c & i_work.d);
            k = K_RND[2];
        end else begin
            f = i_work.b ^ i_work.c ^ i_work.d;
            k = K_RND[3];
        end
    end

    assign t = {i_work.a[26:0], i_work.a[31:27]} + f + i_work.e + k + i_w0;

    assign o_work.a = t;
    assign o_work.b = i_work.a;
    assign o_work.c = {i_work.b[1:0], i_work.b[31:2]};
    assign o_work.d = i_work.c;
    assign o_work.e = i_work.d;

    // w[i+16] = rotl1(w[i+13] ^ w[i+8] ^ w[i+2] ^ w[i])
    assign mix     = i_w13 ^ i_w8 ^ i_w2 ^ i_w0;
    assign o_sched = {mix[30:0], mix[31]};

endmodule

`default_nettype wire

// ===== hdl/sha1_hash_engine.sv =====
// SHA-1 hash engine over a byte stream: top level with sequencer and digest output.
// Depends on sha1_pkg, sha1_round and sha1_hash_engine_macros.svh.
`default_nettype none
`include "sha1_hash_engine_macros.svh"

// Byte-serial SHA-1. Each input item is either an absorb (one message byte) or a
// finish. Bytes shift into a 512-bit block register; when byte 63 of a block lands,
// the single shared round unit runs the 80 rounds, one per cycle, while the block
// register doubles as the 16-word message schedule shift line, then the fold state
// adds the working variables into the chaining value. An absorb that closes a block
// thus goes through shift, 80 rounds and fold. A finish is accepted, then shifts in
// the 0x80 marker, zero fill and the 64-bit big-endian bit length one byte per cycle
// up to the end of the block, then compresses; when the marker lands at byte 56 or
// later a second, zero-filled block carrying the length follows. A finish therefore
// runs accept, pad bytes, 80 rounds and fold, and a second pad, 80 rounds and fold
// in the two-block case, then the digest hand-over. The input stalls while any of
// this runs. The digest then leaves as five items of 32 bits, H0 first, from an
// output register that drains on its own, so absorbs of the next message go on while
// the previous digest waits to be taken; the hand-over of a second finish waits for
// that register to empty. The state is back at the initial hash after every finish.
module sha1_hash_engine (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  logic            i_op,
    input  logic [7:0]      i_data_byte,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output sha1_pkg::t_word o_digest_word,
    output logic [2:0]      o_word_index,
    output logic            o_last_word
);
    import sha1_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_FOLD,
        ST_LOAD
    } t_state;

    t_state       r_state;
    logic [511:0] r_blk;        // block bytes, byte 0 in bits 511..504
    logic [5:0]   r_pos;        // next byte position in the block
    logic [63:0]  r_bits;       // message length in bits
    logic         r_pad_first;  // next pad byte is the 0x80 marker
    logic         r_len_blk;    // this block carries the length field
    logic         r_fin;        // current compression belongs to a finish
    logic [6:0]   r_rnd;
    t_work        r_work;
    t_word        r_h   [DIGEST_LEN];
    t_word        r_dig [DIGEST_LEN];
    logic [2:0]   r_out_left;   // digest words still to deliver

    logic        in_acc;
    logic        out_acc;
    logic        do_shift;
    logic [63:0] len_sh;
    logic [7:0]  len_byte;
    logic [7:0]  pad_byte;
    logic [7:0]  shift_byte;
    t_work       rnd_work;
    t_word       sched;
    t_work       h_work;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;

    // Length bytes go out most significant first at positions 56..63.
    assign len_sh   = r_bits >> {~r_pos[2:0], 3'b000};
    assign len_byte = len_sh[7:0];

    always_comb begin
        if (r_pad_first) begin
            pad_byte = PAD_MARK;
        end else if (r_len_blk && (r_pos >= POS_LEN)) begin
            pad_byte = len_byte;
        end else begin
            pad_byte = 8'h00;
        end
    end

    assign shift_byte = (r_state == ST_PAD) ? pad_byte : i_data_byte;
    assign do_shift   = (r_state == ST_PAD) || (in_acc && (i_op == OP_ABSORB));

    assign h_work = '{a: r_h[0], b: r_h[1], c: r_h[2], d: r_h[3], e: r_h[4]};

    sha1_round u_round (
        .i_work  (r_work),
        .i_rnd   (r_rnd),
        .i_w0    (r_blk[511:480]),
        .i_w2    (r_blk[447:416]),
        .i_w8    (r_blk[255:224]),
        .i_w13   (r_blk[95:64]),
        .o_work  (rnd_work),
        .o_sched (sched)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pos       <= '0;
            r_bits      <= '0;
            r_pad_first <= 1'b0;
            r_len_blk   <= 1'b0;
            r_fin       <= 1'b0;
            r_rnd       <= '0;
            r_out_left  <= '0;
            for (int j = 0; j < DIGEST_LEN; j++) begin
                r_h[j] <= H_INIT[j];
            end
        end else begin
            // Drain the digest one word per taken item.
            if (out_acc) begin
                for (int j = 0; j < DIGEST_LEN - 1; j++) begin
                    r_dig[j] <= r_dig[j + 1];
                end
                r_out_left <= r_out_left - 3'd1;
            end

            // Shift message or pad bytes into the block.
            if (do_shift) begin
                r_blk <= {r_blk[503:0], shift_byte};
                r_pos <= r_pos + 6'd1;
            end

            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        if (i_op == OP_FINISH) begin
                            r_pad_first <= 1'b1;
                            r_fin       <= 1'b1;
                            r_state     <= ST_PAD;
                        end else begin
                            r_bits <= r_bits + 64'd8;
                            r_fin  <= 1'b0;
                            if (r_pos == POS_LAST) begin
                                r_work  <= h_work;
                                r_rnd   <= '0;
                                r_state <= ST_ROUND;
                            end
                        end
                    end
                end
                ST_PAD: begin
                    r_pad_first <= 1'b0;
                    // Room for the length only if the marker lands before byte 56.
                    if (r_pad_first) begin
                        r_len_blk <= (r_pos < POS_LEN);
                    end
                    if (r_pos == POS_LAST) begin
                        r_work  <= h_work;
                        r_rnd   <= '0;
                        r_state <= ST_ROUND;
                    end
                end
                ST_ROUND: begin
                    r_work <= rnd_work;
                    r_blk  <= {r_blk[479:0], sched};
                    r_rnd  <= r_rnd + 7'd1;
                    if (r_rnd == ROUNDS - 7'd1) begin
                        r_state <= ST_FOLD;
                    end
                end
                ST_FOLD: begin
                    r_h[0] <= r_h[0] + r_work.a;
                    r_h[1] <= r_h[1] + r_work.b;
                    r_h[2] <= r_h[2] + r_work.c;
                    r_h[3] <= r_h[3] + r_work.d;
                    r_h[4] <= r_h[4] + r_work.e;
                    if (!r_fin) begin
                        r_state <= ST_IDLE;
                    end else if (!r_len_blk) begin
                        // Marker block done; follow with the zero-filled length block.
                        r_len_blk <= 1'b1;
                        r_state   <= ST_PAD;
                    end else begin
                        r_state <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    // Hand the digest over once the previous one has left.
                    if (r_out_left == '0) begin
                        for (int j = 0; j < DIGEST_LEN; j++) begin
                            r_dig[j] <= r_h[j];
                            r_h[j]   <= H_INIT[j];
                        end
                        r_out_left <= DIGEST_WORDS;
                        r_bits     <= '0;
                        r_len_blk  <= 1'b0;
                        r_fin      <= 1'b0;
                        r_state    <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall    = (r_state != ST_IDLE);
    assign o_out_valid   = (r_out_left != '0);
    assign o_digest_word = r_dig[0];
    assign o_word_index  = DIGEST_WORDS - r_out_left;
    assign o_last_word   = (r_out_left == 3'd1);

    `SHA1_ASSERT_NOW(a_pos_tracks_count, r_state == ST_IDLE, r_pos == r_bits[8:3], "byte position out of step with bit count")
    `SHA1_ASSERT_NOW(a_round_in_range, r_state == ST_ROUND, r_rnd < ROUNDS, "round counter past last round")
    `SHA1_ASSERT_NOW(a_fold_after_last, r_state == ST_FOLD, $past(r_rnd) == ROUNDS - 7'd1, "fold without all rounds")
    `SHA1_ASSERT_NOW(a_pad_in_finish, r_state == ST_PAD, r_fin, "padding outside a finish")
    `SHA1_ASSERT_NEXT(a_load_fills_output, r_state == ST_LOAD && r_out_left == 3'd0, r_out_left == DIGEST_WORDS && r_state == ST_IDLE, "digest not handed over")

endmodule

`default_nettype wire
